// ===== src/itrs_pkg.sv =====
// itrs_pkg: widths, codes and the microcode rom of the integer to radix symbols core
// used by integer_to_radix_symbols_core; no other dependencies
package itrs_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_RADIX  = 16;
  localparam int SYM_BITS   = 8;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = $clog2(MAX_RADIX);
  localparam int DEPTH      = VALUE_BITS;
  localparam int SP_W       = $clog2(DEPTH);
  localparam int CNT_W      = SP_W + 1;
  localparam int BITCNT_W   = $clog2(VALUE_BITS);
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int SYMS_PER_REG = CFG_W / SYM_BITS;

  localparam logic [SYM_BITS-1:0] PLUS_BYTE  = 8'h2B;
  localparam logic [SYM_BITS-1:0] MINUS_BYTE = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_LOAD = 3'd0;
  localparam step_t STEP_DIV  = 3'd1;
  localparam step_t STEP_PUSH = 3'd2;
  localparam step_t STEP_SIGN = 3'd3;
  localparam step_t STEP_POP  = 3'd4;
  localparam step_t STEP_END  = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_PUSH,
    OP_SIGN,
    OP_POP
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_BAD_ALPHA,
    C_DIV_MORE,
    C_MAG_NZ,
    C_MORE_DIGITS
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t jc;
    step_t target;
  } ucode_t;

  // taken jump goes to target, otherwise the next step
  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    unique case (pc)
      STEP_LOAD: w = '{op: OP_LOAD, jc: C_BAD_ALPHA,   target: STEP_LOAD};
      STEP_DIV:  w = '{op: OP_DIV,  jc: C_DIV_MORE,    target: STEP_DIV};
      STEP_PUSH: w = '{op: OP_PUSH, jc: C_MAG_NZ,      target: STEP_DIV};
      STEP_SIGN: w = '{op: OP_SIGN, jc: C_NEVER,       target: STEP_LOAD};
      STEP_POP:  w = '{op: OP_POP,  jc: C_MORE_DIGITS, target: STEP_POP};
      STEP_END:  w = '{op: OP_NOP,  jc: C_ALWAYS,      target: STEP_LOAD};
      default:   w = '{op: OP_NOP,  jc: C_ALWAYS,      target: STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

// ===== src/integer_to_radix_symbols_core.sv =====
// integer_to_radix_symbols_core: signed integer to text in a configured radix and alphabet
// microcoded sequencer over a bit-serial divider and a digit stack; uses itrs_pkg
//
//   channel | signals                          | beat
//   --------+----------------------------------+------------------------------------
//   cfg     | cfg_write cfg_index cfg_data     | one register write, no wait
//   in      | in_valid in_stall value          | one signed integer
//   out     | out_valid out_stall symbol last  | one symbol byte, last on final byte
//
// an integer with d digits runs 32 divide steps and a push per digit in the remainder
// loop, then a sign step that emits the minus byte for a negative number, a pop step
// per digit byte and an end step back to load. with an invalid alphabet the beat is
// taken and dropped in the load step. rst is synchronous and clears the configuration
// registers, the digit count, out_valid and the sequencer. a stall on the output holds
// the sequencer on its emit step; in_stall is high while busy.
module integer_to_radix_symbols_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [itrs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [itrs_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [itrs_pkg::VALUE_BITS-1:0] value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [itrs_pkg::SYM_BITS-1:0]        symbol,
  output logic                                 last
);

  logic [itrs_pkg::RADIX_W-1:0]        radix_length;
  logic [itrs_pkg::CFG_W-1:0]          symbols_low;
  logic [itrs_pkg::CFG_W-1:0]          symbols_high;
  logic [2*itrs_pkg::CFG_W-1:0]        sym_all;
  logic [itrs_pkg::SYM_BITS-1:0]       alphabet [itrs_pkg::MAX_RADIX];
  logic                                alph_bad;

  itrs_pkg::step_t                     pc;
  itrs_pkg::step_t                     pc_next;
  itrs_pkg::ucode_t                    uc;
  logic                                cond_true;
  logic                                hold;
  logic                                out_free;
  logic                                emit;

  logic [itrs_pkg::VALUE_BITS-1:0]     mag;
  logic [itrs_pkg::VALUE_BITS-1:0]     mag_in;
  logic [itrs_pkg::DIGIT_W-1:0]        rem;
  logic [itrs_pkg::DIGIT_W-1:0]        rem_next;
  logic [itrs_pkg::RADIX_W-1:0]        trial;
  logic [itrs_pkg::RADIX_W-1:0]        trial_sub;
  logic                                fits;
  logic                                neg;
  logic [itrs_pkg::BITCNT_W-1:0]       bitcnt;
  logic [itrs_pkg::CNT_W-1:0]          count;
  logic [itrs_pkg::CNT_W-1:0]          count_dec;
  logic [itrs_pkg::DIGIT_W-1:0]        stack [itrs_pkg::DEPTH];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_length <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        itrs_pkg::CFG_RADIX_LENGTH: radix_length <= cfg_data[itrs_pkg::RADIX_W-1:0];
        itrs_pkg::CFG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        itrs_pkg::CFG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sym_all = {symbols_high, symbols_low};

  always_comb begin
    for (int i = 0; i < itrs_pkg::MAX_RADIX; i++) begin
      alphabet[i] = sym_all[i*itrs_pkg::SYM_BITS +: itrs_pkg::SYM_BITS];
    end
  end

  // alphabet check: size, sign bytes, and pairwise repeats among the used symbols
  always_comb begin
    alph_bad = (radix_length < itrs_pkg::RADIX_W'(2))
            || (radix_length > itrs_pkg::RADIX_W'(itrs_pkg::MAX_RADIX));
    for (int i = 0; i < itrs_pkg::MAX_RADIX; i++) begin
      if (itrs_pkg::RADIX_W'(i) < radix_length) begin
        if (alphabet[i] == itrs_pkg::PLUS_BYTE || alphabet[i] == itrs_pkg::MINUS_BYTE) begin
          alph_bad = 1'b1;
        end
        for (int j = i + 1; j < itrs_pkg::MAX_RADIX; j++) begin
          if (itrs_pkg::RADIX_W'(j) < radix_length && alphabet[j] == alphabet[i]) begin
            alph_bad = 1'b1;
          end
        end
      end
    end
  end

  // restoring divide, one quotient bit per cycle shifted into mag
  assign trial     = {rem, mag[itrs_pkg::VALUE_BITS-1]};
  assign fits      = (trial >= radix_length);
  assign trial_sub = trial - radix_length;
  assign rem_next  = fits ? trial_sub[itrs_pkg::DIGIT_W-1:0] : trial[itrs_pkg::DIGIT_W-1:0];

  // magnitude taken unsigned so the most negative value stays exact
  assign mag_in = value[itrs_pkg::VALUE_BITS-1] ? (~value + 1'b1) : value;

  assign count_dec = count - 1'b1;

  // sequencer
  assign uc       = itrs_pkg::ucode_rom(pc);
  assign out_free = !out_valid || !out_stall;
  assign emit     = (uc.op == itrs_pkg::OP_POP) || (uc.op == itrs_pkg::OP_SIGN && neg);
  assign in_stall = (uc.op != itrs_pkg::OP_LOAD);

  always_comb begin
    hold = 1'b0;
    if (uc.op == itrs_pkg::OP_LOAD && !in_valid) begin
      hold = 1'b1;
    end
    if (emit && !out_free) begin
      hold = 1'b1;
    end
  end

  always_comb begin
    unique case (uc.jc)
      itrs_pkg::C_NEVER:       cond_true = 1'b0;
      itrs_pkg::C_ALWAYS:      cond_true = 1'b1;
      itrs_pkg::C_BAD_ALPHA:   cond_true = alph_bad;
      itrs_pkg::C_DIV_MORE:    cond_true = (bitcnt != itrs_pkg::BITCNT_W'(itrs_pkg::VALUE_BITS - 1));
      itrs_pkg::C_MAG_NZ:      cond_true = (mag != '0);
      itrs_pkg::C_MORE_DIGITS: cond_true = (count != itrs_pkg::CNT_W'(1));
      default:                 cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (cond_true) begin
      pc_next = uc.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= itrs_pkg::STEP_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (!hold) begin
      case (uc.op)
        itrs_pkg::OP_LOAD: begin
          mag    <= mag_in;
          neg    <= value[itrs_pkg::VALUE_BITS-1];
          rem    <= '0;
          bitcnt <= '0;
          count  <= '0;
        end
        itrs_pkg::OP_DIV: begin
          mag    <= {mag[itrs_pkg::VALUE_BITS-2:0], fits};
          rem    <= rem_next;
          bitcnt <= bitcnt + 1'b1;
        end
        itrs_pkg::OP_PUSH: begin
          rem    <= '0;
          bitcnt <= '0;
          count  <= count + 1'b1;
        end
        itrs_pkg::OP_POP: begin
          count  <= count_dec;
        end
        default: ;
      endcase
    end
  end

  // digit stack, pushed least significant digit first
  always_ff @(posedge clk) begin
    if (uc.op == itrs_pkg::OP_PUSH) begin
      stack[count[itrs_pkg::SP_W-1:0]] <= rem;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      if (uc.op == itrs_pkg::OP_SIGN) begin
        symbol <= itrs_pkg::MINUS_BYTE;
        last   <= 1'b0;
      end else begin
        symbol <= alphabet[stack[count_dec[itrs_pkg::SP_W-1:0]]];
        last   <= (count == itrs_pkg::CNT_W'(1));
      end
    end
  end

  // the stack never pops empty and never overflows
  assert property (@(posedge clk) disable iff (rst)
    (uc.op == itrs_pkg::OP_POP) |-> (count != '0))
    else $error("digit stack popped while empty");

  assert property (@(posedge clk) disable iff (rst)
    count <= itrs_pkg::CNT_W'(itrs_pkg::DEPTH))
    else $error("digit stack overflow");

  // division only runs on a valid alphabet
  assert property (@(posedge clk) disable iff (rst)
    (uc.op == itrs_pkg::OP_DIV) |-> !alph_bad)
    else $error("divide step with invalid alphabet");

  // a new value is only taken after the previous number ended
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (pc == itrs_pkg::STEP_LOAD || pc == itrs_pkg::STEP_DIV))
    else $error("sequencer left load to an unexpected step");

endmodule

// ===== test/itrs_text_checker.sv =====
// itrs_text_checker: watches the config, input and output channels of the integer to
// radix symbols core, predicts the text of every accepted number and compares it
// depends on itrs_pkg only
`timescale 1ns / 100ps

module itrs_text_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [itrs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [itrs_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic signed [itrs_pkg::VALUE_BITS-1:0] value,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic [itrs_pkg::SYM_BITS-1:0]          symbol,
  input  logic                                   last,
  output int                                     failures,
  output int                                     pending
);

  typedef struct packed {
    logic [itrs_pkg::SYM_BITS-1:0] symbol;
    logic                          last;
  } text_beat_t;

  text_beat_t                   text_q[$];
  logic [itrs_pkg::RADIX_W-1:0] radix_len;
  logic [itrs_pkg::CFG_W-1:0]   syms_lo;
  logic [itrs_pkg::CFG_W-1:0]   syms_hi;

  initial begin
    failures = 0;
    pending  = 0;
  end

  function automatic logic [itrs_pkg::SYM_BITS-1:0] glyph(input int unsigned d);
    if (d < itrs_pkg::SYMS_PER_REG) return syms_lo[d*itrs_pkg::SYM_BITS +: itrs_pkg::SYM_BITS];
    return syms_hi[(d-itrs_pkg::SYMS_PER_REG)*itrs_pkg::SYM_BITS +: itrs_pkg::SYM_BITS];
  endfunction

  // queues the text of one number; an unusable alphabet drops the number
  function automatic void spell_value(input logic [itrs_pkg::VALUE_BITS-1:0] v);
    int unsigned                     base;
    int unsigned                     digits[itrs_pkg::VALUE_BITS];
    int unsigned                     n;
    logic [itrs_pkg::VALUE_BITS-1:0] mag;
    base = radix_len;
    if (base < 2 || base > itrs_pkg::MAX_RADIX) return;
    for (int i = 0; i < base; i++) begin
      if (glyph(i) == itrs_pkg::PLUS_BYTE || glyph(i) == itrs_pkg::MINUS_BYTE) return;
      for (int j = i + 1; j < base; j++)
        if (glyph(j) == glyph(i)) return;
    end
    // unsigned negate, so the most negative value keeps its own bit pattern
    mag = v[itrs_pkg::VALUE_BITS-1] ? ~v + 1'b1 : v;
    n = 0;
    do begin
      digits[n] = mag % base;
      n++;
      mag = mag / base;
    end while (mag != 0);
    if (v[itrs_pkg::VALUE_BITS-1])
      text_q.push_back('{symbol: itrs_pkg::MINUS_BYTE, last: 1'b0});
    for (int i = n - 1; i >= 0; i--)
      text_q.push_back('{symbol: glyph(digits[i]), last: (i == 0)});
  endfunction

  always @(posedge clk) begin
    text_beat_t want;
    if (rst) begin
      radix_len <= '0;
      syms_lo   <= '0;
      syms_hi   <= '0;
      text_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (text_q.size() == 0) begin
          if (failures < 10)
            $display("%0t: symbol %h last %b with no text waiting", $time, symbol, last);
          failures++;
        end else begin
          want = text_q.pop_front();
          if (symbol !== want.symbol || last !== want.last) begin
            if (failures < 10)
              $display("%0t: expected symbol %h last %b, got symbol %h last %b",
                       $time, want.symbol, want.last, symbol, last);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) spell_value(value);
      if (cfg_write) begin
        case (cfg_index)
          itrs_pkg::CFG_RADIX_LENGTH: radix_len <= cfg_data[itrs_pkg::RADIX_W-1:0];
          itrs_pkg::CFG_SYMBOLS_LOW:  syms_lo   <= cfg_data;
          itrs_pkg::CFG_SYMBOLS_HIGH: syms_hi   <= cfg_data;
          default: ;
        endcase
      end
    end
    pending <= text_q.size();
  end

endmodule

// ===== test/tb.sv =====
// tb: stimulus and verdict for integer_to_radix_symbols_core; directed numbers and
// alphabets first, then random phases with random idling on both channels
// depends on itrs_pkg, the core and itrs_text_checker
`timescale 1ns / 100ps

module tb;

  // the limit is sized from the slowest item, 32 binary digits and 33 stalled output beats,
  // and from some 340 items, taken several times over
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 600;

  localparam logic [itrs_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  localparam logic [itrs_pkg::CFG_W-1:0] DEC_LO = "76543210";
  localparam logic [itrs_pkg::CFG_W-1:0] DEC_HI = "------98";
  localparam logic [itrs_pkg::CFG_W-1:0] HEX_HI = "fedcba98";

  logic                                   clk;
  logic                                   rst;
  logic                                   cfg_write;
  logic [itrs_pkg::CFG_IDX_W-1:0]         cfg_index;
  logic [itrs_pkg::CFG_W-1:0]             cfg_data;
  logic                                   in_valid;
  logic                                   in_stall;
  logic signed [itrs_pkg::VALUE_BITS-1:0] value;
  logic                                   out_valid;
  logic                                   out_stall;
  logic [itrs_pkg::SYM_BITS-1:0]          symbol;
  logic                                   last;
  int                                     failures;
  int                                     pending;

  int in_gap_max  = 0;
  int out_gap_max = 0;
  bit hold_out    = 1'b0;
  int cycle_count = 0;

  integer_to_radix_symbols_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .last      (last)
  );

  itrs_text_checker text_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .last      (last),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("integer_to_radix_symbols_core test failed");
      $finish;
    end
  end

  // output side: random stall before each beat, and one long hold on request
  initial begin
    int gap;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic program_regs(input logic [itrs_pkg::CFG_W-1:0] radix_word, lo, hi);
    cfg_write <= 1'b1;
    cfg_index <= itrs_pkg::CFG_RADIX_LENGTH;
    cfg_data  <= radix_word;
    @(negedge clk);
    cfg_index <= itrs_pkg::CFG_SYMBOLS_LOW;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= itrs_pkg::CFG_SYMBOLS_HIGH;
    cfg_data  <= hi;
    @(negedge clk);
    // an unmapped index has to leave the registers alone
    cfg_index <= CFG_UNMAPPED;
    cfg_data  <= {$urandom, $urandom};
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic send_value(input logic [itrs_pkg::VALUE_BITS-1:0] v);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // drain all expected text, then let the sequencer wrap up
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // distinct symbols without sign bytes; spoil breaks the alphabet one way or another
  task automatic make_alphabet(input int width_req, input bit spoil,
                               output logic [itrs_pkg::CFG_W-1:0] radix_word, lo, hi);
    logic [itrs_pkg::SYM_BITS-1:0] alpha [itrs_pkg::MAX_RADIX];
    bit                            taken [256];
    logic [itrs_pkg::SYM_BITS-1:0] c;
    int                            n;
    int                            pos;
    n = (width_req != 0) ? width_req : $urandom_range(2, itrs_pkg::MAX_RADIX);
    for (int i = 0; i < itrs_pkg::MAX_RADIX; i++) begin
      if (i < n) begin
        do begin
          c = itrs_pkg::SYM_BITS'($urandom_range(0, 255));
        end while (taken[c] || c == itrs_pkg::PLUS_BYTE || c == itrs_pkg::MINUS_BYTE);
        taken[c] = 1'b1;
        alpha[i] = c;
      end else begin
        alpha[i] = itrs_pkg::SYM_BITS'($urandom_range(0, 255));
      end
    end
    if (spoil) begin
      pos = $urandom_range(0, n - 1);
      case ($urandom_range(0, 3))
        0: n = $urandom_range(0, 1);
        1: n = $urandom_range(itrs_pkg::MAX_RADIX + 1, (1 << itrs_pkg::RADIX_W) - 1);
        2: alpha[pos] = $urandom_range(0, 1) ? itrs_pkg::PLUS_BYTE : itrs_pkg::MINUS_BYTE;
        default: alpha[(pos == 0) ? 1 : pos] = alpha[0];
      endcase
    end
    radix_word = {$urandom, $urandom};
    radix_word[itrs_pkg::RADIX_W-1:0] = itrs_pkg::RADIX_W'(n);
    for (int i = 0; i < itrs_pkg::MAX_RADIX; i++) begin
      if (i < itrs_pkg::SYMS_PER_REG)
        lo[i*itrs_pkg::SYM_BITS +: itrs_pkg::SYM_BITS] = alpha[i];
      else
        hi[(i-itrs_pkg::SYMS_PER_REG)*itrs_pkg::SYM_BITS +: itrs_pkg::SYM_BITS] = alpha[i];
    end
  endtask

  function automatic logic [itrs_pkg::VALUE_BITS-1:0] random_value();
    logic [itrs_pkg::VALUE_BITS-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = $urandom >> $urandom_range(0, itrs_pkg::VALUE_BITS - 1);
      3: v = $urandom_range(0, 40);
      4: v = -($urandom >> $urandom_range(0, itrs_pkg::VALUE_BITS - 1));
      default: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = '1;
          2: v = {1'b1, {(itrs_pkg::VALUE_BITS-1){1'b0}}};
          default: v = {1'b0, {(itrs_pkg::VALUE_BITS-1){1'b1}}};
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [itrs_pkg::CFG_W-1:0] rw;
    logic [itrs_pkg::CFG_W-1:0] lo;
    logic [itrs_pkg::CFG_W-1:0] hi;
    int                         width_req;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = itrs_pkg::CFG_RADIX_LENGTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    value     = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    in_gap_max  = 2;
    out_gap_max = 2;

    // registers still at reset: empty alphabet, number dropped
    send_value(42);
    settle();

    // unusable alphabets: radix one, radix above sixteen, plus sign, minus sign, repeat
    program_regs(64'd1, DEC_LO, DEC_HI);
    send_value(-5);
    settle();
    program_regs(64'd17, DEC_LO, DEC_HI);
    send_value(123);
    settle();
    program_regs(64'h1F, DEC_LO, DEC_HI);
    send_value(0);
    settle();
    program_regs(64'd10, DEC_LO, "------+8");
    send_value(77);
    settle();
    program_regs(64'd10, "7654-210", DEC_HI);
    send_value(-77);
    settle();
    program_regs(64'd10, "76543213", DEC_HI);
    send_value(31);
    settle();

    // decimal, minus bytes parked beyond the radix
    program_regs(64'd10, DEC_LO, DEC_HI);
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value(9);
    send_value(10);
    send_value(-10);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(-987654321);
    settle();

    program_regs(64'd16, DEC_LO, HEX_HI);
    send_value(32'hDEAD_BEEF);
    send_value(-1);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    settle();

    // binary with a zero byte as digit zero; upper radix bits must be ignored
    program_regs(64'hFFFF_FFFF_FFFF_FFE2, 64'h2B2B_2B2B_2B2B_FF00, 64'h2D2D_2D2D_2D2D_2D2D);
    send_value(32'h8000_0000);
    send_value(-1);
    send_value(0);
    send_value(5);
    settle();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase % 4)
        0: begin
          in_gap_max  = 0;
          out_gap_max = 0;
        end
        1: begin
          in_gap_max  = 8;
          out_gap_max = 8;
        end
        default: begin
          in_gap_max  = $urandom_range(0, 8);
          out_gap_max = $urandom_range(0, 8);
        end
      endcase
      case (phase)
        2: width_req = 2;
        3: width_req = itrs_pkg::MAX_RADIX;
        4: width_req = 10;
        default: width_req = 0;
      endcase
      make_alphabet(width_req, 1'b0, rw, lo, hi);
      program_regs(rw, lo, hi);
      for (int k = 0; k < 30; k++) begin
        // long output hold while the sender keeps offering numbers
        if (phase == 4 && k == 3) hold_out = 1'b1;
        if (phase == 6 && k == 15) settle();
        send_value(random_value());
      end
      settle();
      if (phase % 3 == 2) begin
        make_alphabet(0, 1'b1, rw, lo, hi);
        program_regs(rw, lo, hi);
        repeat (4) send_value(random_value());
        settle();
      end
    end

    if (failures == 0 && pending == 0)
      $display("integer_to_radix_symbols_core test passed");
    else
      $display("integer_to_radix_symbols_core test failed");
    $finish;
  end

endmodule
